>>> design/minibatch_kmeans_centroid_engine_defines.svh
// Assertion macros for the centroid engine.
`ifndef MINIBATCH_KMEANS_CENTROID_ENGINE_DEFINES_SVH
`define MINIBATCH_KMEANS_CENTROID_ENGINE_DEFINES_SVH

// same-cycle implication
`define KMC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define KMC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

>>> design/kmc_pkg.sv
`timescale 1ns / 1ps
// Package: shared widths, codes and payload types of the centroid engine.
package kmc_pkg;

  localparam int COORD_W = 16;
  localparam int SUM_W   = 32;
  localparam int CNT_W   = 16;
  localparam int LIFE_W  = 32;
  localparam int SQ_W    = 32;
  localparam int DIST_W  = 34;
  localparam int ROOT_W  = 17;
  localparam int NUM_W   = 34;
  localparam int DEN_W   = 33;

  localparam int DEF_MAX_CLUSTERS = 16;
  localparam int DEF_MAX_DIMS     = 4;
  localparam int DEF_MAX_BATCH    = 1024;

  typedef enum logic [1:0] {
    CMD_LOAD      = 2'd0,
    CMD_TRAIN     = 2'd1,
    CMD_END_BATCH = 2'd2,
    CMD_PREDICT   = 2'd3
  } cmd_e;

  localparam logic REG_CLUSTER_COUNT = 1'b0;
  localparam logic REG_DIMS_IN_USE   = 1'b1;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [3:0]         cluster_index;
    logic signed [15:0] coord0;
    logic signed [15:0] coord1;
    logic signed [15:0] coord2;
    logic signed [15:0] coord3;
  } point_t;

  typedef struct packed {
    logic        found;
    logic [3:0]  nearest_cluster;
    logic [16:0] distance;
  } result_t;

  typedef struct packed {
    logic cen_load;
    logic cen_update;
    logic sum_write;
    logic mul_load;
    logic div_start;
  } lane_op_t;

endpackage

>>> design/minibatch_kmeans_centroid_engine.sv
`timescale 1ns / 1ps
// Top level: mini-batch k-means centroid engine with per-coordinate lanes.
//
//   channel  | handshake                      | payload
//   point    | point_valid / point_ready      | point  (kmc_pkg::point_t)
//   result   | result_valid / result_ready    | result (kmc_pkg::result_t)
//   config   | psel, penable, pwrite, pready  | paddr, pwdata, prdata
//
// Train/predict: idle, K centroid reads, drain, root start, 17 root steps, then out;
// K = active clusters; train adds a batch-store read and write before the root wait.
// Load: the load state writes one centroid. End batch: untouched slots are skipped, and
// each touched slot runs a 34-step divider per lane, over all MAX_CLUSTERS slots.
// Reset is synchronous; the batch and lifetime stores clear through valid bits at once.
// One transaction is in work at a time; a waiting result does not block the next accept.
module minibatch_kmeans_centroid_engine #(
  parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = kmc_pkg::DEF_MAX_DIMS,
  parameter int MAX_BATCH    = kmc_pkg::DEF_MAX_BATCH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             point_valid,
  output logic             point_ready,
  input  kmc_pkg::point_t  point,
  output logic             result_valid,
  input  logic             result_ready,
  output kmc_pkg::result_t result,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [2:0]       paddr,
  input  logic [31:0]      pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  `include "minibatch_kmeans_centroid_engine_defines.svh"

  localparam int IW  = $clog2(MAX_CLUSTERS);
  localparam int CNW = kmc_pkg::CNT_W;
  localparam int LW  = kmc_pkg::LIFE_W;
  localparam int DNW = kmc_pkg::DEN_W;

  typedef enum logic [3:0] {
    S_IDLE, S_LOAD, S_SCAN, S_DRAIN, S_SQ, S_ACC_RD, S_ACC_WR, S_ROOT, S_OUT,
    S_EB_RD, S_EB_CHK, S_EB_MUL, S_EB_DSTART, S_EB_DWAIT, S_EB_WR, S_EB_END
  } state_t;

  state_t            state;
  kmc_pkg::point_t   item;
  logic [4:0]        cluster_count;
  logic [2:0]        dims_in_use;
  logic [IW-1:0]     scan_i;
  logic [IW-1:0]     eb_i;
  logic [1:0]        drain_cnt;
  logic              loaded;
  logic              res_found;
  logic [CNW-1:0]    n_r;
  logic [DNW-1:0]    den_r;
  logic              bvalid [MAX_CLUSTERS];
  logic              lvalid [MAX_CLUSTERS];

  logic [IW-1:0]     last_idx;
  logic [2:0]        dims_eff;
  logic [IW-1:0]     rd_addr;
  logic [IW-1:0]     wr_addr;
  logic              slot_ok;
  kmc_pkg::lane_op_t lane_op;

  logic [CNW-1:0]    bcnt_mem [MAX_CLUSTERS];
  logic [LW-1:0]     life_mem [MAX_CLUSTERS];
  logic [CNW-1:0]    bcnt_q;
  logic [LW-1:0]     life_q;
  logic              bv_q;
  logic              lv_q;
  logic [CNW-1:0]    cnt_base;
  logic [LW-1:0]     life_base;
  logic              acc_ok;
  logic [LW-1:0]     life_new;

  logic              v1, v2, f1, f2;
  logic [IW-1:0]     i1, i2;

  logic signed [15:0]           pcoord [4];
  logic [kmc_pkg::SQ_W-1:0]     sq_arr [MAX_DIMS];
  logic [MAX_DIMS-1:0]          lane_busy;
  logic [MAX_DIMS-1:0]          lane_active;
  logic                         div_busy;
  logic [kmc_pkg::DIST_W-1:0]   best_dist;
  logic [IW-1:0]                best_idx;
  logic                         sqrt_busy;
  logic [kmc_pkg::ROOT_W-1:0]   root;

  assign pready      = 1'b1;
  assign point_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      cluster_count <= 5'd8;
      dims_in_use   <= 3'd4;
    end else if (psel && penable && pwrite) begin
      if (paddr[2] == kmc_pkg::REG_CLUSTER_COUNT) begin
        cluster_count <= pwdata[4:0];
      end else begin
        dims_in_use <= pwdata[2:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == kmc_pkg::REG_CLUSTER_COUNT) begin
      prdata = 32'(cluster_count);
    end else begin
      prdata = 32'(dims_in_use);
    end
  end

  always_comb begin
    if (cluster_count < 5'd2) begin
      last_idx = IW'(1);
    end else if (int'(cluster_count) > MAX_CLUSTERS) begin
      last_idx = IW'(MAX_CLUSTERS - 1);
    end else begin
      last_idx = IW'(cluster_count - 5'd1);
    end
    if (dims_in_use == 3'd0) begin
      dims_eff = 3'd1;
    end else if (int'(dims_in_use) > MAX_DIMS) begin
      dims_eff = 3'(MAX_DIMS);
    end else begin
      dims_eff = dims_in_use;
    end
  end

  assign slot_ok   = int'(item.cluster_index) < MAX_CLUSTERS;
  assign cnt_base  = bv_q ? bcnt_q : '0;
  assign life_base = lv_q ? life_q : '0;
  assign acc_ok    = cnt_base < CNW'(MAX_BATCH);
  assign life_new  = den_r[DNW-1] ? '1 : den_r[LW-1:0];

  always_comb begin
    unique case (state)
      S_SCAN:                                                   rd_addr = scan_i;
      S_EB_RD, S_EB_CHK, S_EB_MUL, S_EB_DSTART, S_EB_DWAIT,
      S_EB_WR, S_EB_END:                                        rd_addr = eb_i;
      default:                                                  rd_addr = best_idx;
    endcase
    unique case (state)
      S_LOAD:  wr_addr = IW'(item.cluster_index);
      S_EB_WR: wr_addr = eb_i;
      default: wr_addr = best_idx;
    endcase
    lane_op.cen_load   = (state == S_LOAD) && slot_ok;
    lane_op.cen_update = (state == S_EB_WR);
    lane_op.sum_write  = (state == S_ACC_WR) && acc_ok;
    lane_op.mul_load   = (state == S_EB_MUL);
    lane_op.div_start  = (state == S_EB_DSTART);
  end

  always_ff @(posedge clk) begin
    bcnt_q <= bcnt_mem[rd_addr];
    life_q <= life_mem[rd_addr];
    bv_q   <= bvalid[rd_addr];
    lv_q   <= lvalid[rd_addr];
    if (lane_op.sum_write) begin
      bcnt_mem[wr_addr] <= cnt_base + 1'b1;
    end
    if (state == S_EB_WR) begin
      life_mem[wr_addr] <= life_new;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else begin
      v1 <= (state == S_SCAN);
      v2 <= v1;
    end
    f1 <= (scan_i == '0);
    i1 <= scan_i;
    f2 <= f1;
    i2 <= i1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      loaded       <= 1'b0;
      result_valid <= 1'b0;
      res_found    <= 1'b0;
      scan_i       <= '0;
      eb_i         <= '0;
      drain_cnt    <= '0;
      for (int i = 0; i < MAX_CLUSTERS; i++) begin
        bvalid[i] <= 1'b0;
        lvalid[i] <= 1'b0;
      end
    end else begin
      if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (point_valid) begin
            item <= point;
            unique case (point.cmd)
              kmc_pkg::CMD_LOAD: begin
                state <= S_LOAD;
              end
              kmc_pkg::CMD_END_BATCH: begin
                eb_i  <= '0;
                state <= S_EB_RD;
              end
              kmc_pkg::CMD_TRAIN, kmc_pkg::CMD_PREDICT: begin
                res_found <= loaded;
                scan_i    <= '0;
                state     <= loaded ? S_SCAN : S_OUT;
              end
            endcase
          end
        end
        S_LOAD: begin
          if (slot_ok) begin
            bvalid[IW'(item.cluster_index)] <= 1'b0;
            lvalid[IW'(item.cluster_index)] <= 1'b0;
            loaded <= 1'b1;
          end
          state <= S_IDLE;
        end
        S_SCAN: begin
          if (scan_i == last_idx) begin
            drain_cnt <= '0;
            state     <= S_DRAIN;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        S_DRAIN: begin
          if (drain_cnt == 2'd2) begin
            state <= S_SQ;
          end else begin
            drain_cnt <= drain_cnt + 1'b1;
          end
        end
        S_SQ: begin
          state <= (item.cmd == kmc_pkg::CMD_TRAIN) ? S_ACC_RD : S_ROOT;
        end
        S_ACC_RD: begin
          state <= S_ACC_WR;
        end
        S_ACC_WR: begin
          if (acc_ok) begin
            bvalid[best_idx] <= 1'b1;
          end
          state <= S_ROOT;
        end
        S_ROOT: begin
          if (!sqrt_busy) begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!result_valid || result_ready) begin
            result_valid           <= 1'b1;
            result.found           <= res_found;
            result.nearest_cluster <= res_found ? 4'(best_idx) : 4'd0;
            result.distance        <= res_found ? root : '0;
            state                  <= S_IDLE;
          end
        end
        S_EB_RD: begin
          state <= S_EB_CHK;
        end
        S_EB_CHK: begin
          if (cnt_base == '0) begin
            if (int'(eb_i) == MAX_CLUSTERS - 1) begin
              state <= S_EB_END;
            end else begin
              eb_i  <= eb_i + 1'b1;
              state <= S_EB_RD;
            end
          end else begin
            n_r   <= cnt_base;
            den_r <= DNW'(life_base) + DNW'(cnt_base);
            state <= S_EB_MUL;
          end
        end
        S_EB_MUL: begin
          state <= S_EB_DSTART;
        end
        S_EB_DSTART: begin
          state <= S_EB_DWAIT;
        end
        S_EB_DWAIT: begin
          if (!div_busy) begin
            state <= S_EB_WR;
          end
        end
        S_EB_WR: begin
          lvalid[eb_i] <= 1'b1;
          if (int'(eb_i) == MAX_CLUSTERS - 1) begin
            state <= S_EB_END;
          end else begin
            eb_i  <= eb_i + 1'b1;
            state <= S_EB_RD;
          end
        end
        S_EB_END: begin
          for (int i = 0; i < MAX_CLUSTERS; i++) begin
            bvalid[i] <= 1'b0;
          end
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign pcoord[0] = item.coord0;
  assign pcoord[1] = item.coord1;
  assign pcoord[2] = item.coord2;
  assign pcoord[3] = item.coord3;

  for (genvar d = 0; d < MAX_DIMS; d++) begin : g_lane
    assign lane_active[d] = int'(dims_eff) > d;
    kmc_lane #(
      .MAX_CLUSTERS (MAX_CLUSTERS)
    ) u_lane (
      .clk       (clk),
      .rst       (rst),
      .op        (lane_op),
      .rd_addr   (rd_addr),
      .wr_addr   (wr_addr),
      .active    (lane_active[d]),
      .coord     (pcoord[d]),
      .sum_valid (bv_q),
      .batch_n   (n_r),
      .den       (den_r),
      .sq        (sq_arr[d]),
      .div_busy  (lane_busy[d])
    );
  end

  assign div_busy = |lane_busy;

  kmc_merge #(
    .MAX_CLUSTERS (MAX_CLUSTERS),
    .MAX_DIMS     (MAX_DIMS)
  ) u_merge (
    .clk       (clk),
    .rst       (rst),
    .sq        (sq_arr),
    .in_valid  (v2),
    .in_first  (f2),
    .in_idx    (i2),
    .best_dist (best_dist),
    .best_idx  (best_idx)
  );

  kmc_sqrt u_sqrt (
    .clk      (clk),
    .rst      (rst),
    .start    (state == S_SQ),
    .radicand (best_dist),
    .busy     (sqrt_busy),
    .root     (root)
  );

  `KMC_ASSERT_NEXT(a_load_enters_load, point_valid && point_ready && point.cmd == kmc_pkg::CMD_LOAD, state == S_LOAD, "load transaction did not reach load state")
  `KMC_ASSERT_NOW(a_scan_in_range, state == S_SCAN, scan_i <= last_idx, "scan index beyond active clusters")
  `KMC_ASSERT_NOW(a_root_ready_at_out, state == S_OUT, !sqrt_busy, "result formed before root finished")
  `KMC_ASSERT_NOW(a_div_only_in_wait, div_busy, state == S_EB_DWAIT, "divider running outside batch update")

endmodule

>>> design/kmc_div.sv
`timescale 1ns / 1ps
// Module: signed-by-unsigned restoring divider, one quotient bit per cycle.
module kmc_div (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               start,
  input  logic signed [kmc_pkg::NUM_W-1:0]   num,
  input  logic        [kmc_pkg::DEN_W-1:0]   den,
  output logic                               busy,
  output logic signed [kmc_pkg::NUM_W:0]     quo
);

  localparam int NW = kmc_pkg::NUM_W;
  localparam int DW = kmc_pkg::DEN_W;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [DW-1:0] rem;
  logic [DW-1:0] dsr;
  logic          neg;
  logic [CW-1:0] cnt;
  logic [DW:0]   rem_sh;
  logic [DW:0]   diff;
  logic          ge;

  assign rem_sh = {rem, q[NW-1]};
  assign ge     = rem_sh >= {1'b0, dsr};
  assign diff   = rem_sh - {1'b0, dsr};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(NW);
      neg  <= num[NW-1];
      q    <= num[NW-1] ? -num : num;
      rem  <= '0;
      dsr  <= den;
    end else if (busy) begin
      rem <= ge ? diff[DW-1:0] : rem_sh[DW-1:0];
      q   <= {q[NW-2:0], ge};
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

  assign quo = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});

endmodule

>>> design/kmc_sqrt.sv
`timescale 1ns / 1ps
// Module: digit-by-digit floor square root, one root bit per cycle.
module kmc_sqrt (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [kmc_pkg::DIST_W-1:0]   radicand,
  output logic                         busy,
  output logic [kmc_pkg::ROOT_W-1:0]   root
);

  localparam int RW = kmc_pkg::ROOT_W;
  localparam int AW = kmc_pkg::DIST_W;
  localparam int MW = RW + 2;
  localparam int CW = $clog2(RW + 1);

  logic [AW-1:0] rad;
  logic [MW-1:0] rem;
  logic [CW-1:0] cnt;
  logic [MW+1:0] rem_sh;
  logic [MW+1:0] trial;
  logic          ge;

  assign rem_sh = {rem, rad[AW-1:AW-2]};
  assign trial  = (MW+2)'({root, 2'b01});
  assign ge     = rem_sh >= trial;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(RW);
      rad  <= radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad  <= {rad[AW-3:0], 2'b00};
      rem  <= ge ? MW'(rem_sh - trial) : rem_sh[MW-1:0];
      root <= {root[RW-2:0], ge};
      cnt  <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

>>> design/kmc_lane.sv
`timescale 1ns / 1ps
// Module: one coordinate lane: centroid and batch-sum stores, distance term, update.
module kmc_lane #(
  parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  kmc_pkg::lane_op_t                     op,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]       rd_addr,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]       wr_addr,
  input  logic                                  active,
  input  logic signed [kmc_pkg::COORD_W-1:0]    coord,
  input  logic                                  sum_valid,
  input  logic [kmc_pkg::CNT_W-1:0]             batch_n,
  input  logic [kmc_pkg::DEN_W-1:0]             den,
  output logic [kmc_pkg::SQ_W-1:0]              sq,
  output logic                                  div_busy
);

  localparam int CWD = kmc_pkg::COORD_W;
  localparam int SW  = kmc_pkg::SUM_W;
  localparam int NW  = kmc_pkg::NUM_W;

  logic signed [CWD-1:0] cen_mem [MAX_CLUSTERS];
  logic signed [SW-1:0]  sum_mem [MAX_CLUSTERS];
  logic signed [CWD-1:0] cen_q;
  logic signed [SW-1:0]  sum_q;

  logic signed [SW-1:0]  sum_base;
  logic signed [SW-1:0]  sum_acc;
  logic signed [CWD:0]   diff;
  logic signed [2*CWD+1:0] sq_full;

  logic signed [CWD+kmc_pkg::CNT_W:0] nc_q;
  logic signed [CWD-1:0] c_hold;
  logic signed [SW-1:0]  s_hold;
  logic signed [NW-1:0]  num;
  logic signed [NW:0]    quo;
  logic signed [NW+1:0]  cen_sum;
  logic signed [CWD-1:0] cen_new;

  assign sum_base = sum_valid ? sum_q : '0;
  assign sum_acc  = sum_base + (active ? SW'(coord) : '0);
  assign diff     = (CWD+1)'(coord) - (CWD+1)'(cen_q);
  assign sq_full  = diff * diff;
  assign num      = NW'(s_hold) - NW'(nc_q);
  assign cen_sum  = (NW+2)'(c_hold) + (NW+2)'(quo);

  always_comb begin
    if (cen_sum > (NW+2)'(32767)) begin
      cen_new = 16'sh7fff;
    end else if (cen_sum < -(NW+2)'(32768)) begin
      cen_new = -16'sh8000;
    end else begin
      cen_new = cen_sum[CWD-1:0];
    end
  end

  always_ff @(posedge clk) begin
    cen_q <= cen_mem[rd_addr];
    sum_q <= sum_mem[rd_addr];
    if (op.cen_load || (op.cen_update && active)) begin
      cen_mem[wr_addr] <= op.cen_load ? coord : cen_new;
    end
    if (op.sum_write) begin
      sum_mem[wr_addr] <= sum_acc;
    end
  end

  always_ff @(posedge clk) begin
    sq <= active ? sq_full[kmc_pkg::SQ_W-1:0] : '0;
    if (op.mul_load) begin
      nc_q   <= $signed({1'b0, batch_n}) * cen_q;
      c_hold <= cen_q;
      s_hold <= sum_base;
    end
  end

  kmc_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (op.div_start),
    .num   (num),
    .den   (den),
    .busy  (div_busy),
    .quo   (quo)
  );

endmodule

>>> design/kmc_merge.sv
`timescale 1ns / 1ps
// Module: sums the lane distance terms and keeps the running nearest centroid.
module kmc_merge #(
  parameter int MAX_CLUSTERS = kmc_pkg::DEF_MAX_CLUSTERS,
  parameter int MAX_DIMS     = kmc_pkg::DEF_MAX_DIMS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [kmc_pkg::SQ_W-1:0]            sq [MAX_DIMS],
  input  logic                                in_valid,
  input  logic                                in_first,
  input  logic [$clog2(MAX_CLUSTERS)-1:0]     in_idx,
  output logic [kmc_pkg::DIST_W-1:0]          best_dist,
  output logic [$clog2(MAX_CLUSTERS)-1:0]     best_idx
);

  localparam int DW = kmc_pkg::DIST_W;

  logic [DW-1:0]                    total;
  logic [DW-1:0]                    sum_q;
  logic                             v_q;
  logic                             first_q;
  logic [$clog2(MAX_CLUSTERS)-1:0]  idx_q;

  always_comb begin
    total = '0;
    for (int d = 0; d < MAX_DIMS; d++) begin
      total = total + DW'(sq[d]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v_q <= 1'b0;
    end else begin
      v_q <= in_valid;
    end
    sum_q   <= total;
    first_q <= in_first;
    idx_q   <= in_idx;
    if (v_q && (first_q || sum_q < best_dist)) begin
      best_dist <= sum_q;
      best_idx  <= idx_q;
    end
  end

endmodule
